FILE: hdl/ofo_pkg.sv
// Shared types, constants and functions for the optical-flow frame odometry block.
`default_nettype none
package ofo_pkg;

	localparam int FRAME_LENGTH      = 11;
	localparam int TAN_TABLE_ENTRIES = 512;

	localparam logic [7:0] SYNC_BYTE = 8'hFE;
	localparam logic [7:0] ID_BYTE   = 8'h04;
	localparam logic [7:0] TAIL_BYTE = 8'hAA;

	// frame position codes
	localparam logic [3:0] POS_HUNT       = 4'd0;
	localparam logic [3:0] POS_ID         = 4'd1;
	localparam logic [3:0] POS_DATA_FIRST = 4'd2;
	localparam logic [3:0] POS_DATA_LAST  = 4'd7;
	localparam logic [3:0] POS_SUM        = 4'd8;
	localparam logic [3:0] POS_QUAL       = 4'd9;
	localparam logic [3:0] POS_TAIL       = 4'(FRAME_LENGTH - 1);

	// configuration register indexes
	localparam logic [2:0] CFG_CPI_SCALE   = 3'd0;
	localparam logic [2:0] CFG_UPDATE_RATE = 3'd1;
	localparam logic [2:0] CFG_TILT_GAIN   = 3'd2;
	localparam logic [2:0] CFG_QUAL_THRESH = 3'd3;
	localparam logic [2:0] CFG_POOR_LIMIT  = 3'd4;

	localparam logic [15:0] CPI_SCALE_RST   = 16'd6987;
	localparam logic [9:0]  UPDATE_RATE_RST = 10'd50;
	localparam logic [11:0] TILT_GAIN_RST   = 12'd600;
	localparam logic [7:0]  QUAL_THRESH_RST = 8'd25;
	localparam logic [7:0]  POOR_LIMIT_RST  = 8'd20;

	localparam int     ANGLE_90    = 23040;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint ONE_Q30     = 64'sd1073741824;
	localparam longint TAN_CAP_Q16 = 64'sd4194304;
	localparam int     TAN_W       = 23;
	localparam logic [TAN_W-1:0] TAN_CAP = 23'd4194304;

	localparam int OPA_W  = 50;
	localparam int OPB_W  = 18;
	localparam int PROD_W = 68;
	localparam int TGT_W  = 28;

	localparam logic signed [OPB_W-1:0] GAIN_02 = 18'sd13107;
	localparam logic signed [OPB_W-1:0] GAIN_01 = 18'sd6554;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] LAST_STEP = 4'd14;

	typedef struct packed {
		logic [7:0]         rx_byte;
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
	} in_word_t;

	typedef struct packed {
		logic signed [23:0] height_cm;
		logic signed [31:0] pos_x_cm;
		logic signed [31:0] pos_y_cm;
		logic signed [31:0] vel_x_cm_s;
		logic signed [31:0] vel_y_cm_s;
		logic [7:0]         surface_quality;
		logic               poor_environment;
	} out_word_t;

	typedef struct packed {
		logic [15:0] cpi_scale;
		logic [9:0]  update_rate_hz;
		logic [11:0] tilt_gain;
		logic [7:0]  quality_threshold;
		logic [7:0]  poor_frame_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] flow_x;
		logic signed [15:0] flow_y;
		logic signed [15:0] height;
		logic [7:0]         quality;
	} frame_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_FI,
		OP_TGT,
		OP_TT,
		OP_VEL,
		OP_FV,
		OP_POS,
		OP_VOUT,
		OP_HGT
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_IDX,
		ST_ROM,
		ST_RUN,
		ST_DRAIN,
		ST_OUT
	} ctrl_state_t;

	typedef struct packed {
		op_t  op;
		logic axis;
		logic capture;
		logic prep;
		logic rom;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

	// x and y alternate so each op's writeback lands before its axis issues again
	function automatic op_t step_op(input logic [STEP_W-1:0] step);
		op_t r;
		case (step[STEP_W-1:1])
			3'd0:    r = OP_FI;
			3'd1:    r = OP_TGT;
			3'd2:    r = OP_TT;
			3'd3:    r = OP_VEL;
			3'd4:    r = OP_FV;
			3'd5:    r = OP_POS;
			3'd6:    r = OP_VOUT;
			default: r = OP_HGT;
		endcase
		return r;
	endfunction

	function automatic logic signed [39:0] sat40(input logic signed [PROD_W-1:0] v);
		logic signed [39:0] r;
		if (&v[PROD_W-1:39] || ~|v[PROD_W-1:39]) r = v[39:0];
		else if (v[PROD_W-1]) r = {1'b1, 39'd0};
		else r = {1'b0, {39{1'b1}}};
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [PROD_W-1:0] v);
		logic signed [47:0] r;
		if (&v[PROD_W-1:47] || ~|v[PROD_W-1:47]) r = v[47:0];
		else if (v[PROD_W-1]) r = {1'b1, 47'd0};
		else r = {1'b0, {47{1'b1}}};
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [31:0] r;
		if (&v[PROD_W-1:31] || ~|v[PROD_W-1:31]) r = v[31:0];
		else if (v[PROD_W-1]) r = {1'b1, 31'd0};
		else r = {1'b0, {31{1'b1}}};
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/ofo_frm.sv
// Byte-wise frame sync, payload capture and checksum.
`default_nettype none
module ofo_frm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      rx_byte,
	output logic            frame_done,
	output ofo_pkg::frame_t frame
);
	import ofo_pkg::*;

	localparam logic [2:0] QUAL_SLOT = 3'd6;

	logic [3:0] pos_q, pos_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] payload_q [7];
	logic       wr;
	logic [2:0] widx;
	logic       done_c;
	logic [3:0] resync;

	assign resync = (rx_byte == SYNC_BYTE) ? POS_ID : POS_HUNT;

	always_comb begin
		pos_d  = resync;
		sum_d  = sum_q;
		wr     = 1'b0;
		done_c = 1'b0;
		case (pos_q)
			POS_HUNT: pos_d = resync;
			POS_ID: begin
				if (rx_byte == ID_BYTE) begin
					sum_d = 8'd0;
					pos_d = POS_DATA_FIRST;
				end
			end
			POS_SUM: begin
				if (rx_byte == sum_q) pos_d = POS_QUAL;
			end
			POS_QUAL: begin
				wr    = 1'b1;
				pos_d = POS_TAIL;
			end
			POS_TAIL: begin
				if (rx_byte == TAIL_BYTE) begin
					pos_d  = POS_HUNT;
					done_c = 1'b1;
				end
			end
			default: begin
				if (pos_q inside {[POS_DATA_FIRST:POS_DATA_LAST]}) begin
					wr    = 1'b1;
					sum_d = sum_q + rx_byte;
					pos_d = pos_q + 4'd1;
				end
			end
		endcase
	end

	assign widx = (pos_q == POS_QUAL) ? QUAL_SLOT : 3'(pos_q - POS_DATA_FIRST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			sum_q <= 8'd0;
		end else if (accept) begin
			pos_q <= pos_d;
			sum_q <= sum_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && wr) payload_q[widx] <= rx_byte;
	end

	assign frame_done = accept && done_c;

	assign frame.flow_x  = {payload_q[1], payload_q[0]};
	assign frame.flow_y  = {payload_q[3], payload_q[2]};
	assign frame.height  = {payload_q[5], payload_q[4]};
	assign frame.quality = payload_q[QUAL_SLOT];

endmodule
`default_nettype wire

FILE: hdl/ofo_ctrl.sv
// Sequencer: frame handoff, lookup, shared-multiplier schedule, result load.
`default_nettype none
module ofo_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          frame_done,
	input  ofo_pkg::sts_t sts,
	output logic          in_ready,
	output ofo_pkg::cmd_t cmd
);
	import ofo_pkg::*;

	ctrl_state_t       state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		in_ready = 1'b0;
		cmd      = '{op: OP_NONE, axis: 1'b0, capture: 1'b0, prep: 1'b0, rom: 1'b0,
			load: 1'b0};
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = frame_done;
				if (frame_done) state_d = ST_IDX;
			end
			ST_IDX: begin
				cmd.prep = 1'b1;
				state_d  = ST_ROM;
			end
			ST_ROM: begin
				cmd.rom = 1'b1;
				step_d  = '0;
				state_d = ST_RUN;
			end
			ST_RUN: begin
				cmd.op   = step_op(step_q);
				cmd.axis = step_q[0];
				if (step_q == LAST_STEP) state_d = ST_DRAIN;
				else step_d = step_q + 1'b1;
			end
			ST_DRAIN: state_d = ST_OUT;
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/ofo_dp.sv
// Datapath: tan lookup, filter state, shared multiplier with writeback, result register.
`default_nettype none
module ofo_dp #(
	parameter int TAN_ENTRIES = ofo_pkg::TAN_TABLE_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ofo_pkg::cmd_t      cmd,
	input  ofo_pkg::cfg_t      cfg,
	input  ofo_pkg::frame_t    frame,
	input  logic signed [15:0] roll_angle,
	input  logic signed [15:0] pitch_angle,
	input  logic               out_ready,
	output ofo_pkg::sts_t      sts,
	output logic               out_valid,
	output ofo_pkg::out_word_t out_word
);
	import ofo_pkg::*;

	localparam int IDX_W = $clog2(TAN_ENTRIES);
	// floor(mag * entries / 90 deg) as a multiply by a rounded-up reciprocal
	localparam longint RECIP = ((longint'(TAN_ENTRIES) <<< 30) + longint'(ANGLE_90) - 1)
		/ longint'(ANGLE_90);
	localparam logic [31:0] RECIP_K = 32'(RECIP);

	logic [TAN_W-1:0] tan_rom [TAN_ENTRIES];

	// Q30 Taylor series of sin and cos, seven terms each, then Q16 tan capped at 64
	for (genvar g = 0; g < TAN_ENTRIES; g++) begin : g_tan
		localparam longint TanX  = HALF_PI_Q30 * g / TAN_ENTRIES;
		localparam longint TanX2 = (TanX * TanX) >>> 30;
		localparam longint SinT1 = ((TanX * TanX2) >>> 30) / 6;
		localparam longint SinT2 = ((SinT1 * TanX2) >>> 30) / 20;
		localparam longint SinT3 = ((SinT2 * TanX2) >>> 30) / 42;
		localparam longint SinT4 = ((SinT3 * TanX2) >>> 30) / 72;
		localparam longint SinT5 = ((SinT4 * TanX2) >>> 30) / 110;
		localparam longint SinT6 = ((SinT5 * TanX2) >>> 30) / 156;
		localparam longint CosT1 = ((ONE_Q30 * TanX2) >>> 30) / 2;
		localparam longint CosT2 = ((CosT1 * TanX2) >>> 30) / 12;
		localparam longint CosT3 = ((CosT2 * TanX2) >>> 30) / 30;
		localparam longint CosT4 = ((CosT3 * TanX2) >>> 30) / 56;
		localparam longint CosT5 = ((CosT4 * TanX2) >>> 30) / 90;
		localparam longint CosT6 = ((CosT5 * TanX2) >>> 30) / 132;
		localparam longint SinV  = TanX - SinT1 + SinT2 - SinT3 + SinT4 - SinT5 + SinT6;
		localparam longint CosV  = ONE_Q30 - CosT1 + CosT2 - CosT3 + CosT4 - CosT5 + CosT6;
		localparam longint SinP  = (SinV < 0) ? 64'sd0 : SinV;
		localparam longint TanV  = (CosV <= 0) ? TAN_CAP_Q16 : (SinP <<< 16) / CosV;
		localparam longint TanC  = (TanV > TAN_CAP_Q16) ? TAN_CAP_Q16 : TanV;
		assign tan_rom[g] = TAN_W'(TanC);
	end

	logic signed [15:0]       ang_q   [2];
	logic [IDX_W-1:0]         idx_q   [2];
	logic                     cap_q   [2];
	logic                     neg_q   [2];
	logic [TAN_W-1:0]         tan_q   [2];
	logic signed [31:0]       raw_q   [2];
	logic signed [39:0]       fi_q    [2];
	logic signed [31:0]       tt_q    [2];
	logic signed [39:0]       prev_q  [2];
	logic signed [47:0]       fv_q    [2];
	logic signed [TGT_W-1:0]  tgt_q   [2];
	logic signed [47:0]       vr_q    [2];
	logic signed [31:0]       pos_q   [2];
	logic signed [31:0]       vel_q   [2];
	logic signed [23:0]       hgt_q;
	logic [7:0]               poor_q;
	logic signed [39:0]       o_c     [2];
	logic signed [16:0]       ang_ext [2];
	logic [16:0]              mag     [2];
	logic [46:0]              idx_p   [2];

	logic signed [OPA_W-1:0]  opa;
	logic signed [OPB_W-1:0]  opb;
	logic signed [23:0]       tan_sv;
	logic signed [PROD_W-1:0] prod_s1;
	op_t                      op_s1;
	logic                     axis_s1;
	logic signed [PROD_W-1:0] acc;
	logic                     out_valid_q;
	out_word_t                out_q;

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			o_c[k]     = sat40(PROD_W'(fi_q[k]) - PROD_W'(tt_q[k]));
			ang_ext[k] = 17'(ang_q[k]);
			mag[k]     = ang_ext[k][16] ? -ang_ext[k] : ang_ext[k];
			idx_p[k]   = 47'(mag[k][14:0]) * 47'(RECIP_K);
		end
	end

	// operand select for the shared multiplier
	always_comb begin
		tan_sv = $signed({1'b0, tan_q[cmd.axis]});
		if (neg_q[cmd.axis]) tan_sv = -tan_sv;
		opa = '0;
		opb = '0;
		case (cmd.op)
			OP_FI: begin
				opa = OPA_W'($signed({raw_q[cmd.axis], 8'h00})) - OPA_W'(fi_q[cmd.axis]);
				opb = GAIN_02;
			end
			OP_TGT: begin
				opa = OPA_W'(tan_sv);
				opb = $signed({6'd0, cfg.tilt_gain});
			end
			OP_TT: begin
				opa = OPA_W'(tgt_q[cmd.axis]) - OPA_W'(tt_q[cmd.axis]);
				opb = GAIN_02;
			end
			OP_VEL: begin
				opa = OPA_W'(o_c[cmd.axis]) - OPA_W'(prev_q[cmd.axis]);
				opb = $signed({8'd0, cfg.update_rate_hz});
			end
			OP_FV: begin
				opa = OPA_W'(vr_q[cmd.axis]) - OPA_W'(fv_q[cmd.axis]);
				opb = GAIN_01;
			end
			OP_POS: begin
				opa = OPA_W'(prev_q[cmd.axis]);
				opb = $signed({2'd0, cfg.cpi_scale});
			end
			OP_VOUT: begin
				opa = OPA_W'(fv_q[cmd.axis]);
				opb = $signed({2'd0, cfg.cpi_scale});
			end
			OP_HGT: begin
				opa = OPA_W'(frame.height);
				opb = $signed({2'd0, cfg.cpi_scale});
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(opa) * PROD_W'(opb);
		axis_s1 <= cmd.axis;
	end

	always_comb begin
		case (op_s1)
			OP_FI:   acc = PROD_W'(fi_q[axis_s1]) + (prod_s1 >>> 16);
			OP_TT:   acc = PROD_W'(tt_q[axis_s1]) + (prod_s1 >>> 16);
			OP_FV:   acc = PROD_W'(fv_q[axis_s1]) + (prod_s1 >>> 16);
			OP_TGT:  acc = prod_s1 >>> 8;
			OP_HGT:  acc = prod_s1 >>> 8;
			OP_VEL:  acc = prod_s1;
			OP_POS:  acc = prod_s1 >>> 16;
			OP_VOUT: acc = prod_s1 >>> 16;
			default: acc = '0;
		endcase
	end

	// filter state, writeback and frame prep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= OP_NONE;
			poor_q <= 8'd0;
			for (int k = 0; k < 2; k++) begin
				raw_q[k]  <= '0;
				fi_q[k]   <= '0;
				tt_q[k]   <= '0;
				prev_q[k] <= '0;
				fv_q[k]   <= '0;
			end
		end else begin
			op_s1 <= cmd.op;
			if (cmd.prep) begin
				raw_q[0] <= raw_q[0] + 32'(frame.flow_x);
				raw_q[1] <= raw_q[1] + 32'(frame.flow_y);
				if (frame.quality < cfg.quality_threshold) begin
					if (poor_q != 8'hFF) poor_q <= poor_q + 8'd1;
				end else begin
					poor_q <= 8'd0;
				end
			end
			case (op_s1)
				OP_FI: fi_q[axis_s1] <= sat40(acc);
				OP_TT: tt_q[axis_s1] <= sat32(acc);
				OP_FV: fv_q[axis_s1] <= sat48(acc);
				OP_VEL: prev_q[axis_s1] <= o_c[axis_s1];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ang_q[0] <= roll_angle;
			ang_q[1] <= pitch_angle;
		end
		for (int k = 0; k < 2; k++) begin
			if (cmd.prep) begin
				idx_q[k] <= idx_p[k][30 +: IDX_W];
				cap_q[k] <= (mag[k] >= 17'(ANGLE_90));
				neg_q[k] <= ang_q[k][15];
			end
			if (cmd.rom) tan_q[k] <= cap_q[k] ? TAN_CAP : tan_rom[idx_q[k]];
		end
		case (op_s1)
			OP_TGT:  tgt_q[axis_s1] <= acc[TGT_W-1:0];
			OP_VEL:  vr_q[axis_s1]  <= sat48(acc);
			OP_POS:  pos_q[axis_s1] <= sat32(acc);
			OP_VOUT: vel_q[axis_s1] <= sat32(acc);
			OP_HGT:  hgt_q          <= acc[23:0];
			default: ;
		endcase
	end

	// result word register
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.load) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.height_cm        <= hgt_q;
			out_q.pos_x_cm         <= pos_q[0];
			out_q.pos_y_cm         <= pos_q[1];
			out_q.vel_x_cm_s       <= vel_q[0];
			out_q.vel_y_cm_s       <= vel_q[1];
			out_q.surface_quality  <= frame.quality;
			out_q.poor_environment <= (poor_q > cfg.poor_frame_limit);
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule
`default_nettype wire

FILE: hdl/optical_flow_frame_odometry_core.sv
// Top level: configuration registers, framer, sequencer and datapath.
//
//  channel | handshake            | word
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | in_word: rx_byte, roll_angle, pitch_angle
//  out     | out_valid / out_ready| out_word: height, position, velocity, quality
//  cfg     | cfg_wr_en            | cfg_index, cfg_data (no wait, no read-back)
//
// A good tail byte starts the frame math (index, table read, 15 issues on the one shared
// multiplier, drain, load); in_ready is low meanwhile. A result still waiting in the
// output register holds the load, and in_ready stays low until the load happens.
// Reset clears sync state, filter state and the poor-frame counter; the tan table
// is a constant, so there is no clearing pass.
`default_nettype none
module optical_flow_frame_odometry_core #(
	parameter int TAN_ENTRIES = ofo_pkg::TAN_TABLE_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  ofo_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output ofo_pkg::out_word_t out_word,
	input  logic               cfg_wr_en,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	import ofo_pkg::*;

	cfg_t   cfg_q;
	cmd_t   cmd;
	sts_t   sts;
	frame_t frame;
	logic   frame_done;
	logic   in_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cpi_scale         <= CPI_SCALE_RST;
			cfg_q.update_rate_hz    <= UPDATE_RATE_RST;
			cfg_q.tilt_gain         <= TILT_GAIN_RST;
			cfg_q.quality_threshold <= QUAL_THRESH_RST;
			cfg_q.poor_frame_limit  <= POOR_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_CPI_SCALE:   cfg_q.cpi_scale         <= cfg_data;
				CFG_UPDATE_RATE: cfg_q.update_rate_hz    <= cfg_data[9:0];
				CFG_TILT_GAIN:   cfg_q.tilt_gain         <= cfg_data[11:0];
				CFG_QUAL_THRESH: cfg_q.quality_threshold <= cfg_data[7:0];
				CFG_POOR_LIMIT:  cfg_q.poor_frame_limit  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign in_accept = in_valid && in_ready;

	ofo_frm u_frm (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (in_accept),
		.rx_byte    (in_word.rx_byte),
		.frame_done (frame_done),
		.frame      (frame)
	);

	ofo_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.frame_done (frame_done),
		.sts        (sts),
		.in_ready   (in_ready),
		.cmd        (cmd)
	);

	ofo_dp #(
		.TAN_ENTRIES (TAN_ENTRIES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg         (cfg_q),
		.frame       (frame),
		.roll_angle  (in_word.roll_angle),
		.pitch_angle (in_word.pitch_angle),
		.out_ready   (out_ready),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_word    (out_word)
	);

	// a completed frame blocks input until its result is loaded
	a_frame_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> !in_ready)
		else $error("input open right after a frame completed");

	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op != OP_NONE) |-> !in_ready)
		else $error("multiplier issue while input is open");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid || out_ready))
		else $error("result load over an untaken word");

endmodule
`default_nettype wire

FILE: bench/optical_flow_frame_odometry_core_tb.sv
// Self-checking testbench for the optical-flow frame odometry core.
`default_nettype none
module optical_flow_frame_odometry_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ofo_pkg::*;

	localparam int TAN_N = TAN_TABLE_ENTRIES;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_word_t in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_word_t out_word;
	logic cfg_wr_en = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	optical_flow_frame_odometry_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
		.out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("optical_flow_frame_odometry_core regression: fail");
		$finish;
	end

	// ---------------- odometry predictor ----------------
	longint tan_tab [TAN_N];
	cfg_t cur_cfg;
	logic [3:0] sync_pos;
	logic [7:0] frame_bytes [7];
	logic [7:0] byte_sum;
	logic [31:0] flow_acc [2];
	longint flow_lp [2], tilt_lp [2], last_pos [2], vel_lp [2];
	int poor_run;
	out_word_t pending_odo [$];
	int mismatches = 0;
	bit quiet_out = 1'b0;	// no output stalls during a stretch
	int out_hold = 0;

	function automatic longint clamp_bits(input longint v, input int bits);
		longint hi, lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint taylor_q30(input longint x, input bit sine);
		longint x2, term, acc, d;
		x2 = (x * x) >>> 30;
		term = sine ? x : ONE_Q30;
		acc = term;
		for (int n = 1; n <= 6; n++) begin
			d = sine ? 2 * n : 2 * n - 1;
			term = ((term * x2) >>> 30) / (d * (d + 1));
			if (n % 2) acc -= term;
			else acc += term;
		end
		return acc;
	endfunction

	task automatic build_tan_table();
		longint x, s, c, t;
		for (int k = 0; k < TAN_N; k++) begin
			x = HALF_PI_Q30 * k / TAN_N;
			s = taylor_q30(x, 1'b1);
			c = taylor_q30(x, 1'b0);
			if (s < 0) s = 0;
			if (c <= 0) t = TAN_CAP_Q16;
			else t = (s <<< 16) / c;
			tan_tab[k] = t > TAN_CAP_Q16 ? TAN_CAP_Q16 : t;
		end
	endtask

	function automatic longint tilt_tan(input logic signed [15:0] ang);
		longint a, m, idx, t;
		a = ang;
		m = a < 0 ? -a : a;
		idx = m * TAN_N / ANGLE_90;
		t = idx >= TAN_N ? TAN_CAP_Q16 : tan_tab[idx];
		return a < 0 ? -t : t;
	endfunction

	task automatic reset_odometry();
		cur_cfg = '{CPI_SCALE_RST, UPDATE_RATE_RST, TILT_GAIN_RST, QUAL_THRESH_RST,
			POOR_LIMIT_RST};
		sync_pos = POS_HUNT;
		byte_sum = '0;
		poor_run = 0;
		for (int k = 0; k < 2; k++) begin
			flow_acc[k] = '0;
			flow_lp[k] = 0;
			tilt_lp[k] = 0;
			last_pos[k] = 0;
			vel_lp[k] = 0;
		end
	endtask

	task automatic integrate_frame(input in_word_t w);
		out_word_t r;
		longint flow, raw, tgt, o, v, pos [2], vel [2], h;
		logic signed [15:0] ang;
		for (int k = 0; k < 2; k++) begin
			flow = $signed({frame_bytes[2 * k + 1], frame_bytes[2 * k]});
			flow_acc[k] = flow_acc[k] + 32'(flow);
			raw = $signed(flow_acc[k]);
			flow_lp[k] += ((raw * 256 - flow_lp[k]) * 13107) >>> 16;
			flow_lp[k] = clamp_bits(flow_lp[k], 40);
			ang = k ? w.pitch_angle : w.roll_angle;
			tgt = (longint'(cur_cfg.tilt_gain) * tilt_tan(ang)) >>> 8;
			tilt_lp[k] += ((tgt - tilt_lp[k]) * 13107) >>> 16;
			tilt_lp[k] = clamp_bits(tilt_lp[k], 32);
			o = clamp_bits(flow_lp[k] - tilt_lp[k], 40);
			v = clamp_bits((o - last_pos[k]) * longint'(cur_cfg.update_rate_hz), 48);
			last_pos[k] = o;
			vel_lp[k] += ((v - vel_lp[k]) * 6554) >>> 16;
			vel_lp[k] = clamp_bits(vel_lp[k], 48);
			pos[k] = clamp_bits((o * longint'(cur_cfg.cpi_scale)) >>> 16, 32);
			vel[k] = clamp_bits((vel_lp[k] * longint'(cur_cfg.cpi_scale)) >>> 16, 32);
		end
		if (frame_bytes[6] < cur_cfg.quality_threshold) begin
			if (poor_run < 255) poor_run++;
		end else begin
			poor_run = 0;
		end
		h = $signed({frame_bytes[5], frame_bytes[4]});
		r.height_cm = 24'((h * longint'(cur_cfg.cpi_scale)) >>> 8);
		r.pos_x_cm = 32'(pos[0]);
		r.pos_y_cm = 32'(pos[1]);
		r.vel_x_cm_s = 32'(vel[0]);
		r.vel_y_cm_s = 32'(vel[1]);
		r.surface_quality = frame_bytes[6];
		r.poor_environment = poor_run > cur_cfg.poor_frame_limit;
		pending_odo.push_back(r);
	endtask

	task automatic track_byte(input in_word_t w);
		logic [7:0] b;
		logic [3:0] resync;
		b = w.rx_byte;
		resync = (b == SYNC_BYTE) ? POS_ID : POS_HUNT;
		if (sync_pos == POS_HUNT) begin
			sync_pos = resync;
		end else if (sync_pos == POS_ID) begin
			if (b == ID_BYTE) begin
				byte_sum = '0;
				sync_pos = POS_DATA_FIRST;
			end else begin
				sync_pos = resync;
			end
		end else if (sync_pos >= POS_DATA_FIRST && sync_pos <= POS_DATA_LAST) begin
			frame_bytes[3'(sync_pos - POS_DATA_FIRST)] = b;
			byte_sum += b;
			sync_pos = sync_pos + 4'd1;
		end else if (sync_pos == POS_SUM) begin
			sync_pos = (b == byte_sum) ? POS_QUAL : resync;
		end else if (sync_pos == POS_QUAL) begin
			frame_bytes[6] = b;
			sync_pos = POS_TAIL;
		end else if (sync_pos == POS_TAIL) begin
			if (b == TAIL_BYTE) begin
				sync_pos = POS_HUNT;
				integrate_frame(w);
			end else begin
				sync_pos = resync;
			end
		end else begin
			sync_pos = resync;
		end
	endtask

	// ---------------- result checking ----------------
	// mostly short output stalls, now and then a long one
	always @(posedge clk) begin
		if (quiet_out) begin
			out_ready <= 1'b1;
		end else if (out_hold > 0) begin
			out_hold--;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 2) begin
			out_hold = $urandom_range(10, 40);
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) < 70);
		end
	end

	task automatic check_field(input string name, input logic [31:0] exp_v,
		input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// valid/ready only move at rising edges, so the falling edge sees the handshake
	always @(negedge clk) begin
		out_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_odo.size() == 0) begin
				$error("result word with nothing expected");
				mismatches++;
			end else begin
				e = pending_odo.pop_front();
				check_field("height_cm", 32'(e.height_cm), 32'(out_word.height_cm));
				check_field("pos_x_cm", e.pos_x_cm, out_word.pos_x_cm);
				check_field("pos_y_cm", e.pos_y_cm, out_word.pos_y_cm);
				check_field("vel_x_cm_s", e.vel_x_cm_s, out_word.vel_x_cm_s);
				check_field("vel_y_cm_s", e.vel_y_cm_s, out_word.vel_y_cm_s);
				check_field("surface_quality", 32'(e.surface_quality),
					32'(out_word.surface_quality));
				check_field("poor_environment", 32'(e.poor_environment),
					32'(out_word.poor_environment));
			end
		end
	end

	// ---------------- stimulus ----------------
	bit quiet_in = 1'b0;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_in || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [15:0] pick_angle();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 16'sd23040;
		if (r == 1) return -16'sd23040;
		if (r == 2) return 16'sd0;
		return 16'($signed($urandom_range(0, 46080)) - 23040);
	endfunction

	// called just after a rising edge; returns just after the accepting edge, or after the random gap that follows it
	task automatic send_word(input logic [7:0] b, input logic signed [15:0] roll,
		input logic signed [15:0] pitch);
		in_word_t w;
		int gap;
		w = '{b, roll, pitch};
		in_valid <= 1'b1;
		in_word <= w;
		forever begin
			@(negedge clk);
			if (in_ready) break;
		end
		@(posedge clk);
		track_byte(w);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(b, pick_angle(), pick_angle());
	endtask

	typedef enum int {FR_GOOD, FR_BAD_ID, FR_BAD_SUM, FR_BAD_TAIL, FR_CUT} frame_kind_t;

	task automatic send_frame(input frame_kind_t kind, input logic [15:0] fx,
		input logic [15:0] fy, input logic [15:0] fh, input logic [7:0] q,
		input logic signed [15:0] roll, input logic signed [15:0] pitch);
		logic [7:0] d [6];
		logic [7:0] s;
		int cut;
		d = '{fx[7:0], fx[15:8], fy[7:0], fy[15:8], fh[7:0], fh[15:8]};
		s = '0;
		foreach (d[i]) s += d[i];
		cut = $urandom_range(0, 5);
		send_byte(SYNC_BYTE);
		send_byte(kind == FR_BAD_ID ? ID_BYTE ^ 8'(1 << $urandom_range(0, 7)) : ID_BYTE);
		if (kind == FR_BAD_ID) return;
		foreach (d[i]) begin
			if (kind == FR_CUT && i == cut) begin
				send_byte(SYNC_BYTE);	// sync byte mid frame, then the frame is abandoned
				return;
			end
			send_byte(d[i]);
		end
		send_byte(kind == FR_BAD_SUM ? s + 8'($urandom_range(1, 255)) : s);
		send_byte(q);
		send_word(kind == FR_BAD_TAIL ? (($urandom_range(0, 1)) ? SYNC_BYTE : 8'h55)
			: TAIL_BYTE, roll, pitch);
	endtask

	task automatic random_frame(input frame_kind_t kind, input bit low_q);
		logic [7:0] q;
		q = low_q ? 8'($urandom_range(0, 30)) : 8'($urandom_range(0, 255));
		send_frame(kind, 16'($urandom), 16'($urandom), 16'($urandom), q,
			pick_angle(), pick_angle());
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_odo.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic load_config(input cfg_t c);
		logic [15:0] v [5];
		v = '{16'(c.cpi_scale), 16'(c.update_rate_hz), 16'(c.tilt_gain),
			16'(c.quality_threshold), 16'(c.poor_frame_limit)};
		for (int i = 0; i < 5; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= 3'(i);
			// bits above the register width are junk the core must drop
			cfg_data <= v[i] | (16'($urandom) & ~(i == CFG_CPI_SCALE ? 16'hFFFF :
				i == CFG_UPDATE_RATE ? 16'h03FF : i == CFG_TILT_GAIN ? 16'h0FFF : 16'h00FF));
			@(posedge clk);
		end
		// index beyond the register file must be dropped
		cfg_index <= 3'($urandom_range(5, 7));
		cfg_data <= 16'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		cur_cfg = c;
	endtask

	task automatic test_directed();
		send_frame(FR_GOOD, 16'h7FFF, 16'h8000, 16'h7FFF, 8'd255, 16'sd23040, -16'sd23040);
		send_frame(FR_GOOD, 16'h8000, 16'h7FFF, 16'h8000, 8'd0, -16'sd23040, 16'sd23040);
		send_frame(FR_GOOD, 16'h0000, 16'hFFFF, 16'h0000, 8'd25, 16'sd0, 16'sd0);
		send_frame(FR_GOOD, 16'hFFFF, 16'h0001, 16'h0100, 8'd24, 16'sd22995, -16'sd45);
		send_frame(FR_BAD_ID, 16'h1234, 16'h5678, 16'h0100, 8'd100, 16'sd0, 16'sd0);
		send_frame(FR_BAD_SUM, 16'h1234, 16'h5678, 16'h0100, 8'd100, 16'sd0, 16'sd0);
		send_frame(FR_BAD_TAIL, 16'h1234, 16'h5678, 16'h0100, 8'd100, 16'sd0, 16'sd0);
		send_frame(FR_CUT, 16'h1234, 16'h5678, 16'h0100, 8'd100, 16'sd0, 16'sd0);
		send_byte(SYNC_BYTE);	// FE FE 04 must still lock
		send_frame(FR_GOOD, 16'h00FE, 16'hFE04, 16'hAAFE, 8'hAA, 16'sd11520, -16'sd11520);
		wait_drained();
	endtask

	task automatic test_config_sweep();
		cfg_t c;
		// zero rate and zero scale, then all extremes
		load_config('{16'd0, 10'd0, 12'd0, 8'd0, 8'd0});
		repeat (3) random_frame(FR_GOOD, 1'b0);
		wait_drained();
		load_config('{16'hFFFF, 10'd1023, 12'd4095, 8'd255, 8'd0});
		repeat (4) random_frame(FR_GOOD, 1'b0);
		wait_drained();
		load_config('{16'hFFFF, 10'd1, 12'd4095, 8'd255, 8'd255});
		repeat (3) random_frame(FR_GOOD, 1'b0);
		wait_drained();
		for (int p = 0; p < 6; p++) begin
			c.cpi_scale = 16'($urandom);
			c.update_rate_hz = 10'($urandom_range(1, 1000));
			c.tilt_gain = 12'($urandom);
			c.quality_threshold = 8'($urandom_range(0, 40));
			c.poor_frame_limit = 8'($urandom_range(0, 6));
			load_config(c);
			repeat (6) random_frame(FR_GOOD, 1'b1);
			wait_drained();
		end
	endtask

	task automatic test_random_stream();
		cfg_t c;
		int r;
		for (int p = 0; p < 8; p++) begin
			c.cpi_scale = 16'($urandom);
			c.update_rate_hz = 10'($urandom_range(1, 1000));
			c.tilt_gain = 12'($urandom);
			c.quality_threshold = 8'($urandom);
			c.poor_frame_limit = 8'($urandom_range(0, 30));
			load_config(c);
			quiet_in = (p % 3 == 1);
			quiet_out = (p % 3 == 2);
			for (int f = 0; f < 15; f++) begin
				r = $urandom_range(0, 99);
				if (r < 75) random_frame(FR_GOOD, p[0]);
				else if (r < 80) random_frame(FR_BAD_ID, 1'b0);
				else if (r < 85) random_frame(FR_BAD_SUM, 1'b0);
				else if (r < 90) random_frame(FR_BAD_TAIL, 1'b0);
				else if (r < 95) random_frame(FR_CUT, 1'b0);
				else repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			end
			quiet_in = 1'b0;
			quiet_out = 1'b0;
			wait_drained();
		end
	endtask

	initial begin
		build_tan_table();
		reset_odometry();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_sweep();
		test_random_stream();
		wait_drained();
		if (mismatches == 0 && pending_odo.size() == 0)
			$display("optical_flow_frame_odometry_core regression: pass");
		else
			$display("optical_flow_frame_odometry_core regression: fail");
		$finish;
	end

endmodule
`default_nettype wire
